[rtl/dihedral_torsion_energy_defines.svh]
// Assertion macros shared by the torsion energy checker.
`ifndef DIHEDRAL_TORSION_ENERGY_DEFINES_SVH
`define DIHEDRAL_TORSION_ENERGY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DTE_ASSERT_SAME(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DTE_ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dte_pkg.sv]
// Shared constants and types for the dihedral torsion energy pipeline.
package dte_pkg;

    // Number of register stages in one cosine pipeline.
    localparam int COS_LAT = 29;

    // Number of Taylor terms after the leading one.
    localparam int TERMS = 8;

    // Fixed widths of the Q30 cosine arithmetic.
    localparam int X_W   = 31;
    localparam int X2_W  = 32;
    localparam int N_W   = 33;
    localparam int T_W   = 32;
    localparam int SUM_W = 34;

    localparam logic [X_W-1:0]         HALF_PI_Q30 = 31'd1686629713;
    localparam logic [T_W-1:0]         ONE_Q30_U   = 32'd1073741824;
    localparam logic signed [SUM_W-1:0] ONE_Q30    = 34'sd1073741824;

    typedef struct packed {
        logic signed [31:0] c0;
        logic signed [31:0] c1;
        logic signed [31:0] c2;
        logic signed [31:0] c3;
    } coef_t;

endpackage

[rtl/dte_cos_pipe.sv]
// Pipelined fixed-point cosine of a phase given as a fraction of a full turn.
module dte_cos_pipe #(
    parameter int ANGLE_BITS    = 16,
    parameter int COS_FRAC_BITS = 15
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic [ANGLE_BITS-1:0]           phase,
    output logic signed [COS_FRAC_BITS+1:0] cos_val
);
    import dte_pkg::*;

    localparam int R_W  = ANGLE_BITS - 2;
    localparam int Q_W  = ANGLE_BITS - 1;
    localparam int XP_W = Q_W + X_W;
    localparam int CW   = COS_FRAC_BITS + 2;
    localparam logic [Q_W-1:0] QUARTER   = {1'b1, {R_W{1'b0}}};
    localparam logic [XP_W-1:0] X_ROUND  = XP_W'(QUARTER >> 1);
    localparam logic [2*X_W:0] SQ_ROUND  = (2*X_W+1)'(1) << 29;
    localparam logic [30:0] MAG_ROUND    = 31'(1) << (29 - COS_FRAC_BITS);

    // Fold the phase into the first quadrant.
    logic [1:0]     quad;
    logic [R_W-1:0] rem;
    logic [Q_W-1:0] q_next;
    logic [Q_W-1:0] q_reg;
    logic           neg1_reg;

    assign quad   = phase[ANGLE_BITS-1 -: 2];
    assign rem    = phase[R_W-1:0];
    assign q_next = quad[0] ? QUARTER - Q_W'(rem) : Q_W'(rem);

    // Angle in radians, Q30.
    logic [XP_W-1:0] xprod;
    logic [X_W-1:0]  x_next;
    logic [X_W-1:0]  x_reg;
    logic            neg2_reg;

    assign xprod  = XP_W'(q_reg) * XP_W'(HALF_PI_Q30) + X_ROUND;
    assign x_next = X_W'(xprod >> R_W);

    // Square of the angle, Q30.
    logic [2*X_W:0]  xsq;
    logic [X2_W-1:0] x2_next;
    logic [X2_W-1:0] x2_reg;
    logic            neg3_reg;

    assign xsq     = (2*X_W+1)'(x_reg) * (2*X_W+1)'(x_reg) + SQ_ROUND;
    assign x2_next = xsq[30 +: X2_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg    <= q_next;
            neg1_reg <= quad[0] ^ quad[1];
            x_reg    <= x_next;
            neg2_reg <= neg1_reg;
            x2_reg   <= x2_next;
            neg3_reg <= neg2_reg;
        end
    end

    // Index k carries the running sum before term k is applied, and term k itself.
    logic [X2_W-1:0]         x2_w   [0:TERMS];
    logic                    neg_w  [0:TERMS];
    logic signed [SUM_W-1:0] sum_w  [0:TERMS];
    logic [T_W-1:0]          term_w [0:TERMS];

    assign x2_w[0]   = x2_reg;
    assign neg_w[0]  = neg3_reg;
    assign sum_w[0]  = '0;
    assign term_w[0] = ONE_Q30_U;

    for (genvar k = 1; k <= TERMS; k++)
    begin : g_term
        localparam int DIV = (2 * k - 1) * (2 * k);
        localparam logic [N_W-1:0]   RECIP = N_W'((66'd1 << N_W) / DIV);
        localparam logic [N_W+7:0]   DIV_W = (N_W+8)'(DIV);

        // Stage A: term times x squared, and fold the previous term into the sum.
        logic [T_W+X2_W-1:0]     tprod;
        logic signed [SUM_W-1:0] prev_term;
        logic [N_W-1:0]          a_n_next;
        logic signed [SUM_W-1:0] a_sum_next;
        logic [N_W-1:0]          a_n_reg;
        logic [X2_W-1:0]         a_x2_reg;
        logic                    a_neg_reg;
        logic signed [SUM_W-1:0] a_sum_reg;

        assign tprod      = (T_W+X2_W)'(term_w[k-1]) * (T_W+X2_W)'(x2_w[k-1]);
        assign a_n_next   = tprod[30 +: N_W];
        assign prev_term  = signed'(SUM_W'(term_w[k-1]));
        assign a_sum_next = ((k - 1) % 2 == 0) ? sum_w[k-1] + prev_term
                                               : sum_w[k-1] - prev_term;

        // Stage B: quotient estimate by reciprocal, low by at most one.
        logic [2*N_W-1:0]        rprod;
        logic [N_W-1:0]          b_q_reg;
        logic [N_W-1:0]          b_n_reg;
        logic [X2_W-1:0]         b_x2_reg;
        logic                    b_neg_reg;
        logic signed [SUM_W-1:0] b_sum_reg;

        assign rprod = (2*N_W)'(a_n_reg) * (2*N_W)'(RECIP);

        // Stage C: correct the estimate from the remainder.
        logic [N_W+7:0]          qd;
        logic [N_W+7:0]          rest;
        logic [T_W-1:0]          c_term_next;
        logic [T_W-1:0]          c_term_reg;
        logic [X2_W-1:0]         c_x2_reg;
        logic                    c_neg_reg;
        logic signed [SUM_W-1:0] c_sum_reg;

        assign qd          = (N_W+8)'(b_q_reg) * DIV_W;
        assign rest        = (N_W+8)'(b_n_reg) - qd;
        assign c_term_next = T_W'(b_q_reg + N_W'(rest >= DIV_W));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_n_reg    <= a_n_next;
                a_x2_reg   <= x2_w[k-1];
                a_neg_reg  <= neg_w[k-1];
                a_sum_reg  <= a_sum_next;
                b_q_reg    <= rprod[N_W +: N_W];
                b_n_reg    <= a_n_reg;
                b_x2_reg   <= a_x2_reg;
                b_neg_reg  <= a_neg_reg;
                b_sum_reg  <= a_sum_reg;
                c_term_reg <= c_term_next;
                c_x2_reg   <= b_x2_reg;
                c_neg_reg  <= b_neg_reg;
                c_sum_reg  <= b_sum_reg;
            end
        end

        assign x2_w[k]   = c_x2_reg;
        assign neg_w[k]  = c_neg_reg;
        assign sum_w[k]  = c_sum_reg;
        assign term_w[k] = c_term_reg;
    end

    // Last term is added, then the sum is clamped, rounded and signed.
    logic signed [SUM_W-1:0] fsum_next;
    logic signed [SUM_W-1:0] fsum_reg;
    logic                    fneg_reg;
    logic signed [SUM_W-1:0] clamped;
    logic [30:0]             rnd;
    logic signed [CW-1:0]    mag_s;
    logic signed [CW-1:0]    cos_next;
    logic signed [CW-1:0]    cos_reg;

    assign fsum_next = sum_w[TERMS] + signed'(SUM_W'(term_w[TERMS]));

    always_comb
    begin
        if (fsum_reg < 0)
            clamped = '0;
        else if (fsum_reg > ONE_Q30)
            clamped = ONE_Q30;
        else
            clamped = fsum_reg;
        rnd      = 31'(clamped) + MAG_ROUND;
        mag_s    = signed'({1'b0, rnd[30 -: (COS_FRAC_BITS + 1)]});
        cos_next = fneg_reg ? -mag_s : mag_s;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fsum_reg <= fsum_next;
            fneg_reg <= neg_w[TERMS];
            cos_reg  <= cos_next;
        end
    end

    assign cos_val = cos_reg;

endmodule

[rtl/dihedral_torsion_energy.sv]
// Top level of the pipelined cosine-series dihedral torsion energy block.
//
// Each request carries a dihedral angle, as an unsigned fraction of a full turn
// (2^ANGLE_BITS is one turn, higher bits of angle_turns are ignored), and four
// signed Q24.8 coefficients c0..c3. The block returns
// E = c0 + c1(1 + cos a) + c2(1 - cos 2a) + c3(1 + cos 3a) in signed Q24.8,
// rounded half toward plus infinity and saturated to 32 bits; overflow marks a
// saturated result. The three cosines come from three identical cosine
// pipelines that evaluate a Q30 Taylor series (nine terms, each after the first a
// multiply, a reciprocal divide and a correction step) and round it to COS_FRAC_BITS
// fraction bits, so the results match a quarter-wave table built the same way.
// A new request is taken every cycle while req_ready is high. The accepting clock
// edge loads the first of 35 register stages: 29 cosine stages, five stages that
// form the factors, products, sums and the rounded, saturated energy, and the
// output register. A skid register behind the output register lets the pipeline
// move one more step while a result waits; req_ready drops only when that skid
// register is full, and then the whole pipeline holds until the waiting result is
// taken. The block keeps no state between requests.
module dihedral_torsion_energy #(
    parameter int ANGLE_BITS    = 16,
    parameter int COS_FRAC_BITS = 15
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [15:0]        angle_turns,
    input  logic signed [31:0] coef_const,
    input  logic signed [31:0] coef_first,
    input  logic signed [31:0] coef_second,
    input  logic signed [31:0] coef_third,
    output logic               res_valid,
    input  logic               res_ready,
    output logic signed [31:0] energy,
    output logic               overflow
);
    import dte_pkg::*;

    localparam int CW    = COS_FRAC_BITS + 2;   // signed cosine width
    localparam int PW    = CW + 31;             // product width
    localparam int SW    = PW + 2;              // sum width
    localparam int VLD_N = COS_LAT + 5;
    localparam logic signed [CW:0]   ONE_EXT = signed'((CW+1)'(1) << COS_FRAC_BITS);
    localparam logic signed [SW-1:0] HALF    = signed'(SW'(1) << (COS_FRAC_BITS - 1));

    // The whole pipeline advances together unless the skid register is holding
    // a result that found the output register occupied.
    logic en;
    logic skid_valid_reg;
    logic out_valid_reg;

    assign en        = !skid_valid_reg;
    assign req_ready = en;

    // Valid bits travel alongside the data, one per stage.
    logic [VLD_N-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[VLD_N-2:0], req_valid};
    end

    // Phases a, 2a and 3a, all wrapping modulo one turn.
    logic [ANGLE_BITS-1:0] p1;
    logic [ANGLE_BITS-1:0] p2;
    logic [ANGLE_BITS-1:0] p3;

    assign p1 = ANGLE_BITS'({{ANGLE_BITS{1'b0}}, angle_turns});
    assign p2 = {p1[ANGLE_BITS-2:0], 1'b0};
    assign p3 = p1 + p2;

    logic signed [CW-1:0] cos1;
    logic signed [CW-1:0] cos2;
    logic signed [CW-1:0] cos3;

    dte_cos_pipe #(
        .ANGLE_BITS    (ANGLE_BITS),
        .COS_FRAC_BITS (COS_FRAC_BITS)
    ) u_cos1 (
        .clk     (clk),
        .en      (en),
        .phase   (p1),
        .cos_val (cos1)
    );

    dte_cos_pipe #(
        .ANGLE_BITS    (ANGLE_BITS),
        .COS_FRAC_BITS (COS_FRAC_BITS)
    ) u_cos2 (
        .clk     (clk),
        .en      (en),
        .phase   (p2),
        .cos_val (cos2)
    );

    dte_cos_pipe #(
        .ANGLE_BITS    (ANGLE_BITS),
        .COS_FRAC_BITS (COS_FRAC_BITS)
    ) u_cos3 (
        .clk     (clk),
        .en      (en),
        .phase   (p3),
        .cos_val (cos3)
    );

    // Coefficients wait in a delay line matched to the cosine pipelines.
    coef_t coef_pipe_reg [0:COS_LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coef_pipe_reg[0] <= '{c0: coef_const, c1: coef_first,
                                  c2: coef_second, c3: coef_third};
            for (int i = 1; i < COS_LAT; i++)
                coef_pipe_reg[i] <= coef_pipe_reg[i-1];
        end
    end

    // Stage E1: harmonic factors, each in [0, 2] with COS_FRAC_BITS fraction bits.
    logic signed [CW:0] f1s;
    logic signed [CW:0] f2s;
    logic signed [CW:0] f3s;
    logic [CW-1:0]      fac1_reg;
    logic [CW-1:0]      fac2_reg;
    logic [CW-1:0]      fac3_reg;
    coef_t              e1_coef_reg;

    assign f1s = ONE_EXT + (CW+1)'(cos1);
    assign f2s = ONE_EXT - (CW+1)'(cos2);
    assign f3s = ONE_EXT + (CW+1)'(cos3);

    // Stage E2: coefficient products.
    logic signed [PW-1:0] prod0_next;
    logic signed [PW-1:0] prod1_next;
    logic signed [PW-1:0] prod2_next;
    logic signed [PW-1:0] prod3_next;
    logic signed [PW-1:0] prod0_reg;
    logic signed [PW-1:0] prod1_reg;
    logic signed [PW-1:0] prod2_reg;
    logic signed [PW-1:0] prod3_reg;

    assign prod0_next = PW'(e1_coef_reg.c0) <<< COS_FRAC_BITS;
    assign prod1_next = PW'(e1_coef_reg.c1) * signed'(PW'(fac1_reg));
    assign prod2_next = PW'(e1_coef_reg.c2) * signed'(PW'(fac2_reg));
    assign prod3_next = PW'(e1_coef_reg.c3) * signed'(PW'(fac3_reg));

    // Stages E3 and E4: the four products are summed as a two-level tree.
    logic signed [SW-1:0] s01_reg;
    logic signed [SW-1:0] s23_reg;
    logic signed [SW-1:0] sum_reg;

    // Stage E5: round half up to Q24.8 and saturate to 32 bits.
    logic signed [SW-1:0] t_round;
    logic signed [SW-1:0] r_round;
    logic                 sat;
    logic signed [31:0]   rnd_energy_next;
    logic signed [31:0]   rnd_energy_reg;
    logic                 rnd_ovf_reg;

    always_comb
    begin
        t_round = sum_reg + HALF;
        r_round = t_round >>> COS_FRAC_BITS;
        sat     = (r_round[SW-1:31] != '0) && (r_round[SW-1:31] != '1);
        if (!sat)
            rnd_energy_next = r_round[31:0];
        else if (r_round[SW-1])
            rnd_energy_next = 32'sh8000_0000;
        else
            rnd_energy_next = 32'sh7fff_ffff;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fac1_reg       <= f1s[CW-1:0];
            fac2_reg       <= f2s[CW-1:0];
            fac3_reg       <= f3s[CW-1:0];
            e1_coef_reg    <= coef_pipe_reg[COS_LAT-1];
            prod0_reg      <= prod0_next;
            prod1_reg      <= prod1_next;
            prod2_reg      <= prod2_next;
            prod3_reg      <= prod3_next;
            s01_reg        <= SW'(prod0_reg) + SW'(prod1_reg);
            s23_reg        <= SW'(prod2_reg) + SW'(prod3_reg);
            sum_reg        <= s01_reg + s23_reg;
            rnd_energy_reg <= rnd_energy_next;
            rnd_ovf_reg    <= sat;
        end
    end

    // Output register with a one-entry skid register behind it.
    logic               last_valid;
    logic               out_free;
    logic signed [31:0] out_energy_reg;
    logic               out_ovf_reg;
    logic signed [31:0] skid_energy_reg;
    logic               skid_ovf_reg;

    assign last_valid = vld_reg[VLD_N-1] && en;
    assign out_free   = res_ready || !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= last_valid;
            end
        end
        else if (last_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_energy_reg <= skid_energy_reg;
                out_ovf_reg    <= skid_ovf_reg;
            end
            else if (last_valid)
            begin
                out_energy_reg <= rnd_energy_reg;
                out_ovf_reg    <= rnd_ovf_reg;
            end
        end
        else if (last_valid)
        begin
            skid_energy_reg <= rnd_energy_reg;
            skid_ovf_reg    <= rnd_ovf_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign energy    = out_energy_reg;
    assign overflow  = out_ovf_reg;

endmodule

[rtl/dte_checker.sv]
// Port-level checker for the dihedral torsion energy block, bound to its top level.
`include "dihedral_torsion_energy_defines.svh"

module dte_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               res_valid,
    input logic               res_ready,
    input logic signed [31:0] energy,
    input logic               overflow
);

    // A stalled result stays, unchanged, until it is taken.
    `DTE_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(energy) && $stable(overflow), "result dropped or changed while stalled")

    // A saturated result sits at one of the two range limits.
    `DTE_ASSERT_SAME(a_ovf_limit, clk, rst_n, res_valid && overflow, energy == 32'sh7fff_ffff || energy == 32'sh8000_0000, "overflow set on an unsaturated energy")

    // The block refuses requests only while a result is waiting.
    `DTE_ASSERT_SAME(a_ready_wait, clk, rst_n, !req_ready, res_valid, "request refused with no result waiting")

    // Back pressure on requests follows a stalled result in the cycle before.
    `DTE_ASSERT_SAME(a_ready_cause, clk, rst_n, !req_ready && !req_valid || !req_ready && req_valid, $past(res_valid && !res_ready), "request refused without a prior output stall")

endmodule

bind dihedral_torsion_energy dte_checker u_dte_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .energy    (energy),
    .overflow  (overflow)
);
